@@ rtl/wpd_pkg.sv @@
// Shared types, codes and tables for the WAV PCM to PWM duty block.
// Used by wpd_parser, wpd_res_fifo and wav_pcm_to_pwm_duty_unit.
package wpd_pkg;

	// parse phases
	localparam logic [3:0] PH_RIFF    = 4'd0;
	localparam logic [3:0] PH_RSIZE   = 4'd1;
	localparam logic [3:0] PH_WAVE    = 4'd2;
	localparam logic [3:0] PH_CID     = 4'd3;
	localparam logic [3:0] PH_CSIZE   = 4'd4;
	localparam logic [3:0] PH_FMT     = 4'd5;
	localparam logic [3:0] PH_SKIP    = 4'd6;
	localparam logic [3:0] PH_SAMPLES = 4'd7;
	localparam logic [3:0] PH_DRAIN   = 4'd8;

	// big-endian tag words as collected by the shift register
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_HDR    = 2'd2;
	localparam logic [1:0] KIND_FMT    = 2'd3;

	localparam logic [6:0] VOL_MAX   = 7'd100;
	localparam logic [6:0] VOL_RESET = 7'd80;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] duty;
		logic       run_last;
	} res_t;

	// up to two results produced by one byte
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// floor(p*p*180/10000), at least 1 for p above zero
	localparam logic [7:0] DUTY_MAX_TBL [0:100] = '{
		8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,
		8'd7,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
		8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd22,  8'd23,  8'd24,  8'd25,  8'd27,
		8'd28,  8'd30,  8'd31,  8'd33,  8'd34,  8'd36,  8'd38,  8'd39,  8'd41,  8'd43,
		8'd45,  8'd46,  8'd48,  8'd50,  8'd52,  8'd54,  8'd56,  8'd58,  8'd60,  8'd62,
		8'd64,  8'd66,  8'd69,  8'd71,  8'd73,  8'd76,  8'd78,  8'd80,  8'd83,  8'd85,
		8'd88,  8'd90,  8'd93,  8'd95,  8'd98,  8'd101, 8'd103, 8'd106, 8'd109, 8'd112,
		8'd115, 8'd118, 8'd121, 8'd124, 8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd142,
		8'd145, 8'd149, 8'd152, 8'd155, 8'd159, 8'd162, 8'd165, 8'd169, 8'd172, 8'd176,
		8'd180
	};

	function automatic logic [7:0] duty_max_of(input logic [6:0] p);
		logic [7:0] d;
		if (p > VOL_MAX) begin
			d = DUTY_MAX_TBL[VOL_MAX];
		end else begin
			d = DUTY_MAX_TBL[p];
		end
		return d;
	endfunction

endpackage

@@ rtl/wpd_res_fifo.sv @@
// Small register FIFO for results; takes up to two entries per cycle.
// Depends on wpd_pkg for res_t, push_t and the depth constants.
module wpd_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  wpd_pkg::push_t push,
	output logic          room2,
	output logic          result_valid,
	input  logic          result_stall,
	output wpd_pkg::res_t head
);
	import wpd_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	logic [FIFO_AW-1:0] wr_p1;

	assign result_valid = (count_q != '0);
	assign pop          = result_valid && !result_stall;
	assign room2        = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign head         = mem_q[rd_q];
	assign wr_p1        = wr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.n);
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
		end
	end

endmodule

@@ rtl/wpd_parser.sv @@
// RIFF/WAVE chunk walker and sample-to-duty mapper, one byte per enabled cycle.
// Depends on wpd_pkg for phase codes, tags, kinds and push_t.
module wpd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [7:0]     b,
	input  logic           last,
	input  logic [7:0]     dmax,
	output wpd_pkg::push_t push
);
	import wpd_pkg::*;

	logic [3:0]  phase_q, n_phase;
	logic [31:0] fbc_q, n_fbc;
	logic [31:0] tag_q, n_tag;
	logic [31:0] len_q, n_len;
	logic [15:0] fmt_q, n_fmt;
	logic [15:0] chan_q, n_chan;
	logic [15:0] sbits_q, n_sbits;
	logic        rnz_q, n_rnz;
	logic [31:0] dleft_q, n_dleft;
	logic [7:0]  hold_q, n_hold;

	logic [31:0] tw_tag, tw_len, tw_cnt, bps, total, fbc_p1;
	logic        tw_done, ended, have, fmt_ok;
	logic [16:0] raw, mag;
	logic [7:0]  amp;
	logic [15:0] prod;
	logic [1:0]  nres;
	logic [1:0]  rk [2];
	logic [7:0]  rd [2];

	assign tw_tag  = {tag_q[23:0], b};
	assign tw_len  = {b, len_q[31:8]};
	assign tw_cnt  = fbc_q + 32'd1;
	assign tw_done = (fbc_q >= 32'd3);
	assign bps     = (sbits_q == 16'd16) ? 32'd2 : 32'd1;
	assign total   = (len_q > 32'd16) ? len_q : 32'd16;
	assign fbc_p1  = fbc_q + 32'd1;
	assign raw     = {1'b0, b, hold_q};
	assign mag     = raw[15] ? (17'h10000 - raw) : raw;
	assign fmt_ok  = (fmt_q == 16'd1) && (chan_q == 16'd1) &&
	                 ((sbits_q == 16'd8) || (sbits_q == 16'd16)) &&
	                 rnz_q && (tw_len != 32'd0);

	always_comb begin
		n_phase = phase_q;
		n_fbc   = fbc_q;
		n_tag   = tag_q;
		n_len   = len_q;
		n_fmt   = fmt_q;
		n_chan  = chan_q;
		n_sbits = sbits_q;
		n_rnz   = rnz_q;
		n_dleft = dleft_q;
		n_hold  = hold_q;
		ended   = 1'b0;
		have    = 1'b0;
		amp     = 8'd0;
		nres    = 2'd0;
		rk[0]   = KIND_SAMPLE;
		rk[1]   = KIND_SAMPLE;
		rd[0]   = 8'd0;
		rd[1]   = 8'd0;

		if ((phase_q == PH_RIFF) || (phase_q == PH_RSIZE) || (phase_q == PH_WAVE) ||
		    (phase_q == PH_CID) || (phase_q == PH_CSIZE)) begin
			n_tag = tw_tag;
			n_len = tw_len;
			n_fbc = tw_done ? 32'd0 : tw_cnt;
		end

		case (phase_q)
			PH_RIFF: begin
				if (tw_done) begin
					if (tw_tag != TAG_RIFF) begin
						rk[nres[0]] = KIND_HDR;
						nres = nres + 2'd1;
						ended = 1'b1;
					end else begin
						n_phase = PH_RSIZE;
						n_len = 32'd0;
					end
				end
			end
			PH_RSIZE: begin
				if (tw_done) begin
					if (tw_len == 32'd0) begin
						rk[nres[0]] = KIND_HDR;
						nres = nres + 2'd1;
						ended = 1'b1;
					end else begin
						n_phase = PH_WAVE;
					end
				end
			end
			PH_WAVE: begin
				if (tw_done) begin
					if (tw_tag != TAG_WAVE) begin
						rk[nres[0]] = KIND_HDR;
						nres = nres + 2'd1;
						ended = 1'b1;
					end else begin
						n_phase = PH_CID;
					end
				end
			end
			PH_CID: begin
				if (tw_done) begin
					n_phase = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				// chunk id was parked in dleft_q when the id completed
				if (tw_done) begin
					if (dleft_q == TAG_FMT) begin
						n_phase = PH_FMT;
					end else if (dleft_q == TAG_DATA) begin
						if (!fmt_ok) begin
							rk[nres[0]] = KIND_FMT;
							nres = nres + 2'd1;
							ended = 1'b1;
						end else if ((dmax == 8'd0) || (tw_len < bps)) begin
							rk[nres[0]] = KIND_DONE;
							nres = nres + 2'd1;
							ended = 1'b1;
						end else begin
							n_dleft = tw_len;
							n_phase = PH_SAMPLES;
						end
					end else if (tw_len == 32'd0) begin
						n_phase = PH_CID;
					end else begin
						n_phase = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				if (fbc_q == 32'd0) begin
					n_fmt = {8'd0, b};
				end else if (fbc_q == 32'd1) begin
					n_fmt = fmt_q | {b, 8'd0};
				end else if (fbc_q == 32'd2) begin
					n_chan = {8'd0, b};
				end else if (fbc_q == 32'd3) begin
					n_chan = chan_q | {b, 8'd0};
				end else if (fbc_q == 32'd4) begin
					n_rnz = (b != 8'd0);
				end else if (fbc_q <= 32'd7) begin
					n_rnz = rnz_q | (b != 8'd0);
				end else if (fbc_q == 32'd14) begin
					n_sbits = {8'd0, b};
				end else if (fbc_q == 32'd15) begin
					n_sbits = sbits_q | {b, 8'd0};
				end
				if (fbc_p1 >= total) begin
					n_fbc = 32'd0;
					n_phase = PH_CID;
				end else begin
					n_fbc = fbc_p1;
				end
			end
			PH_SKIP: begin
				n_len = len_q - 32'd1;
				if (n_len == 32'd0) begin
					n_phase = PH_CID;
				end
			end
			PH_SAMPLES: begin
				if (sbits_q == 16'd8) begin
					amp = (b >= 8'd128) ? (b - 8'd128) : (8'd128 - b);
					n_dleft = dleft_q - 32'd1;
					have = 1'b1;
				end else if (fbc_q == 32'd0) begin
					n_hold = b;
					n_fbc = 32'd1;
				end else begin
					amp = mag[15:8];
					n_fbc = 32'd0;
					n_dleft = dleft_q - 32'd2;
					have = 1'b1;
				end
				if (have) begin
					rk[nres[0]] = KIND_SAMPLE;
					rd[nres[0]] = prod[14:7];
					nres = nres + 2'd1;
				end
				if ((n_fbc == 32'd0) && (n_dleft < bps)) begin
					rk[nres[0]] = KIND_DONE;
					nres = nres + 2'd1;
					ended = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if ((n_phase == PH_CSIZE) && (n_fbc == 32'd0) && !ended) begin
			n_dleft = n_tag;
		end

		if (last && !ended) begin
			if (n_phase <= PH_WAVE) begin
				rk[nres[0]] = KIND_HDR;
				nres = nres + 2'd1;
			end else if (n_phase <= PH_SKIP) begin
				rk[nres[0]] = KIND_FMT;
				nres = nres + 2'd1;
			end else if (n_phase == PH_SAMPLES) begin
				rk[nres[0]] = KIND_DONE;
				nres = nres + 2'd1;
			end
		end

		// end of file rearms the parser
		if (last) begin
			n_phase = PH_RIFF;
			n_fbc   = 32'd0;
			n_tag   = 32'd0;
			n_len   = 32'd0;
			n_fmt   = 16'd0;
			n_chan  = 16'd0;
			n_sbits = 16'd0;
			n_rnz   = 1'b0;
			n_dleft = 32'd0;
			n_hold  = 8'd0;
		end else if (ended) begin
			n_phase = PH_DRAIN;
		end
	end

	assign prod = {8'd0, amp} * {8'd0, dmax};

	always_comb begin
		push.n           = en ? nres : 2'd0;
		push.r0.kind     = rk[0];
		push.r0.duty     = rd[0];
		push.r0.run_last = (nres == 2'd1);
		push.r1.kind     = rk[1];
		push.r1.duty     = rd[1];
		push.r1.run_last = (nres == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			fbc_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			fmt_q   <= '0;
			chan_q  <= '0;
			sbits_q <= '0;
			rnz_q   <= 1'b0;
			dleft_q <= '0;
			hold_q  <= '0;
		end else if (en) begin
			phase_q <= n_phase;
			fbc_q   <= n_fbc;
			tag_q   <= n_tag;
			len_q   <= n_len;
			fmt_q   <= n_fmt;
			chan_q  <= n_chan;
			sbits_q <= n_sbits;
			rnz_q   <= n_rnz;
			dleft_q <= n_dleft;
			hold_q  <= n_hold;
		end
	end

endmodule

@@ rtl/wav_pcm_to_pwm_duty_unit.sv @@
// WAV PCM to PWM duty: top level with volume register, input stage and result queue.
// Depends on wpd_pkg, wpd_parser and wpd_res_fifo.
// Throughput: one file byte per cycle while the queue has room for two; results leave singly.
// Path: a byte is registered in the input stage, then its results are written into the queue.
// Reset clears parser state and queue and sets volume to 80; no clearing pass is needed.
// Per-byte rate is set by the single parser update and the result queue write port.
module wav_pcm_to_pwm_duty_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  duty,
	output logic        run_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wpd_pkg::*;

	logic [6:0] vol_q;
	logic [7:0] dmax_q;
	logic [6:0] wr_vol;
	logic       cfg_wr;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       proc;
	logic       accept;
	logic       room2;
	push_t      push;
	res_t       head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign wr_vol = (pwdata[6:0] > VOL_MAX) ? VOL_MAX : pwdata[6:0];
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, vol_q} : 32'd0;

	// duty ceiling is looked up once per register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= VOL_RESET;
			dmax_q <= duty_max_of(VOL_RESET);
		end else if (cfg_wr) begin
			vol_q  <= wr_vol;
			dmax_q <= duty_max_of(wr_vol);
		end
	end

	assign proc       = valid_s1 && room2;
	assign byte_stall = valid_s1 && !room2;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	wpd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc),
		.b      (byte_s1),
		.last   (last_s1),
		.dmax   (dmax_q),
		.push   (push)
	);

	wpd_res_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room2        (room2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign kind     = head.kind;
	assign duty     = head.duty;
	assign run_last = head.run_last;

endmodule

@@ verif/wpd_duty_checker.sv @@
// Checker for wav_pcm_to_pwm_duty_unit: watches the byte, result and register ports,
// predicts the duty results of each accepted byte and compares them in order.
// Depends on wpd_pkg for phase, tag and result codes.
module wpd_duty_checker #(
	parameter logic [2:0] VOL_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  duty,
	input  logic        run_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	import wpd_pkg::*;

	logic [6:0]  vol;
	logic [3:0]  ph;
	logic [31:0] nbytes;
	logic [31:0] tag_sr;
	logic [31:0] clen;
	logic [31:0] left;
	logic [15:0] fmt_code;
	logic [15:0] n_chan;
	logic [15:0] bits_ps;
	logic        rate_ok;
	logic [7:0]  lo_hold;
	res_t        duty_results[$];
	int          mismatches;

	function automatic logic [7:0] peak_duty(input logic [6:0] p);
		int d;
		d = (int'(p) * int'(p) * 180) / 10000;
		if (p != 0 && d < 1) begin
			d = 1;
		end
		return d[7:0];
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic clear_parse();
		ph       = PH_RIFF;
		nbytes   = '0;
		tag_sr   = '0;
		clen     = '0;
		left     = '0;
		fmt_code = '0;
		n_chan   = '0;
		bits_ps  = '0;
		rate_ok  = 1'b0;
		lo_hold  = '0;
	endtask

	// one file byte: advance the parse state and queue the results it causes
	task automatic parse_wav_byte(input logic [7:0] b, input logic l);
		res_t        out [0:1];
		int          n;
		logic        ended;
		logic        word_done;
		logic        have;
		logic [31:0] need;
		logic [31:0] total;
		logic [31:0] amp;
		logic [31:0] mag;
		logic [31:0] prod;
		logic [15:0] raw;
		logic [7:0]  dmax;
		n = 0;
		ended = 1'b0;
		word_done = 1'b0;
		have = 1'b0;
		amp = '0;
		dmax = peak_duty(vol);
		need = {16'd0, bits_ps} / 32'd8;
		// tag and size words are collected together and share one byte counter
		if (ph <= PH_CSIZE) begin
			tag_sr = {tag_sr[23:0], b};
			clen   = {b, clen[31:8]};
			nbytes = nbytes + 1;
			if (nbytes >= 4) begin
				nbytes = '0;
				word_done = 1'b1;
			end
		end
		case (ph)
			PH_RIFF: begin
				if (word_done) begin
					if (tag_sr != TAG_RIFF) begin
						out[n] = {KIND_HDR, 8'd0, 1'b0}; n++; ended = 1'b1;
					end else begin
						ph = PH_RSIZE;
						clen = '0;
					end
				end
			end
			PH_RSIZE: begin
				if (word_done) begin
					if (clen == 0) begin
						out[n] = {KIND_HDR, 8'd0, 1'b0}; n++; ended = 1'b1;
					end else begin
						ph = PH_WAVE;
					end
				end
			end
			PH_WAVE: begin
				if (word_done) begin
					if (tag_sr != TAG_WAVE) begin
						out[n] = {KIND_HDR, 8'd0, 1'b0}; n++; ended = 1'b1;
					end else begin
						ph = PH_CID;
					end
				end
			end
			PH_CID: begin
				if (word_done) begin
					ph = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				// left still holds the chunk id saved when the id word completed
				if (word_done) begin
					if (left == TAG_FMT) begin
						ph = PH_FMT;
					end else if (left == TAG_DATA) begin
						if (fmt_code != 16'd1 || n_chan != 16'd1 ||
								!(bits_ps == 16'd8 || bits_ps == 16'd16) ||
								!rate_ok || clen == 0) begin
							out[n] = {KIND_FMT, 8'd0, 1'b0}; n++; ended = 1'b1;
						end else if (dmax == 0 || clen < need) begin
							out[n] = {KIND_DONE, 8'd0, 1'b0}; n++; ended = 1'b1;
						end else begin
							left = clen;
							ph = PH_SAMPLES;
						end
					end else if (clen == 0) begin
						ph = PH_CID;
					end else begin
						ph = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				total = (clen > 32'd16) ? clen : 32'd16;
				case (nbytes)
					0: fmt_code = {8'd0, b};
					1: fmt_code = fmt_code | {b, 8'd0};
					2: n_chan = {8'd0, b};
					3: n_chan = n_chan | {b, 8'd0};
					4: rate_ok = (b != 0);
					5, 6, 7: rate_ok = rate_ok | (b != 0);
					14: bits_ps = {8'd0, b};
					15: bits_ps = bits_ps | {b, 8'd0};
					default: ;
				endcase
				nbytes = nbytes + 1;
				if (nbytes >= total) begin
					nbytes = '0;
					ph = PH_CID;
				end
			end
			PH_SKIP: begin
				clen = clen - 1;
				if (clen == 0) begin
					ph = PH_CID;
				end
			end
			PH_SAMPLES: begin
				if (bits_ps == 16'd8) begin
					amp = (b >= 8'd128) ? {24'd0, b} - 32'd128 : 32'd128 - {24'd0, b};
					left = left - 1;
					have = 1'b1;
				end else if (nbytes == 0) begin
					lo_hold = b;
					nbytes = 32'd1;
				end else begin
					raw = {b, lo_hold};
					mag = raw[15] ? 32'h1_0000 - {16'd0, raw} : {16'd0, raw};
					amp = mag >> 8;
					nbytes = '0;
					left = left - 2;
					have = 1'b1;
				end
				if (have) begin
					prod = (amp * {24'd0, dmax}) / 32'd128;
					out[n] = {KIND_SAMPLE, prod[7:0], 1'b0}; n++;
				end
				if (nbytes == 0 && left < need) begin
					out[n] = {KIND_DONE, 8'd0, 1'b0}; n++; ended = 1'b1;
				end
			end
			default: ;
		endcase
		if (ph == PH_CSIZE && nbytes == 0 && !ended) begin
			left = tag_sr;
		end
		if (l && !ended) begin
			if (ph <= PH_WAVE) begin
				out[n] = {KIND_HDR, 8'd0, 1'b0}; n++;
			end else if (ph <= PH_SKIP) begin
				out[n] = {KIND_FMT, 8'd0, 1'b0}; n++;
			end else if (ph == PH_SAMPLES) begin
				out[n] = {KIND_DONE, 8'd0, 1'b0}; n++;
			end
		end
		if (l) begin
			clear_parse();
		end else if (ended) begin
			ph = PH_DRAIN;
		end
		if (n > 0) begin
			out[n-1].run_last = 1'b1;
			for (int i = 0; i < n; i++) begin
				duty_results.push_back(out[i]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			clear_parse();
			vol = VOL_RESET;
			duty_results.delete();
			mismatches = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = {kind, duty, run_last};
				if (duty_results.size() == 0) begin
					flag($sformatf("result with nothing expected: kind %0d duty %0d last %0d",
						got.kind, got.duty, got.run_last));
				end else begin
					want = duty_results.pop_front();
					if (got.kind !== want.kind || got.duty !== want.duty ||
							got.run_last !== want.run_last) begin
						flag($sformatf("kind/duty/last expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.kind, want.duty, want.run_last,
							got.kind, got.duty, got.run_last));
					end
				end
			end
			if (psel && penable && pready && paddr == VOL_ADDR) begin
				if (pwrite) begin
					vol = (pwdata[6:0] > VOL_MAX) ? VOL_MAX : pwdata[6:0];
				end else if (prdata !== {25'd0, vol}) begin
					flag($sformatf("volume read expected %0d got %0d", vol, prdata));
				end
			end
			if (byte_valid && !byte_stall) begin
				parse_wav_byte(data_byte, last_byte);
			end
			pending <= duty_results.size();
			errors <= mismatches;
		end
	end

endmodule

@@ verif/tb_wav_pcm_to_pwm_duty_unit.sv @@
// Testbench top for wav_pcm_to_pwm_duty_unit: builds WAV byte streams, drives them with
// random idling and stalls, programs the volume register and reports the verdict.
// Depends on wpd_pkg, the block RTL and wpd_duty_checker.
module tb_wav_pcm_to_pwm_duty_unit;
	import wpd_pkg::*;

	localparam logic [2:0]  VOL_ADDR    = 3'd0;
	localparam int          QUIET_LIMIT = 3000;
	localparam logic [31:0] TAG_LIST    = 32'h4C49_5354;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  kind;
	logic [7:0]  duty;
	logic        run_last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;

	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_off = 0;
	int          quiet_cycles = 0;
	int          bytes_sent = 0;
	logic [7:0]  file_q[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	wav_pcm_to_pwm_duty_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .duty(duty), .run_last(run_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	wpd_duty_checker #(.VOL_ADDR(VOL_ADDR)) u_chk (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .duty(duty), .run_last(run_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	// result side: random stalls, or a counted hold-off when one is requested
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_stall = 1'b1;
				hold_off--;
			end else begin
				result_stall = ($urandom_range(99) < recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic put_le(input logic [31:0] v, input int nb);
		for (int i = 0; i < nb; i++) begin
			file_q.push_back(v[8*i +: 8]);
		end
	endtask

	task automatic put_tag(input logic [31:0] t);
		file_q.push_back(t[31:24]);
		file_q.push_back(t[23:16]);
		file_q.push_back(t[15:8]);
		file_q.push_back(t[7:0]);
	endtask

	task automatic truncate_to(input int len);
		while (file_q.size() > len) begin
			file_q.delete(file_q.size() - 1);
		end
	endtask

	// RIFF/WAVE file; the fmt body is always at least 16 bytes long, whatever size it claims
	task automatic make_wav(input int fcode, input int chans, input logic [31:0] rate,
			input int bits, input int fsize, input int dsize, input int ndata, input int junk);
		file_q.delete();
		put_tag(TAG_RIFF);
		put_le(36 + ndata, 4);
		put_tag(TAG_WAVE);
		if (junk >= 0) begin
			put_tag(TAG_LIST);
			put_le(junk, 4);
			repeat (junk) file_q.push_back($urandom_range(255));
		end
		put_tag(TAG_FMT);
		put_le(fsize, 4);
		put_le(fcode, 2);
		put_le(chans, 2);
		put_le(rate, 4);
		put_le(rate * (bits / 8), 4);
		put_le(bits / 8, 2);
		put_le(bits, 2);
		for (int i = 16; i < fsize; i++) begin
			file_q.push_back($urandom_range(255));
		end
		put_tag(TAG_DATA);
		put_le(dsize, 4);
		repeat (ndata) file_q.push_back($urandom_range(255));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		data_byte = b;
		last_byte = l;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			send_byte(file_q[i], i == file_q.size() - 1);
			bytes_sent++;
		end
	endtask

	task automatic wait_drained();
		byte_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = VOL_ADDR;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// only while idle; upper data bits are noise the register should drop
	task automatic set_volume(input logic [6:0] v);
		wait_drained();
		apb_access(1'b1, ($urandom() & 32'hFFFF_FF80) | {25'd0, v});
		apb_access(1'b0, 32'd0);
	endtask

	task automatic random_file();
		int r;
		int bits;
		int fsize;
		int dsize;
		r = $urandom_range(99);
		if (r < 85) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: bits = 8;
				5, 6, 7, 8: bits = 16;
				default: bits = $urandom_range(32);
			endcase
			fsize = ($urandom_range(2) == 0) ? $urandom_range(24) : 16;
			dsize = $urandom_range(24);
			make_wav(($urandom_range(9) == 0) ? $urandom_range(3) : 1,
				($urandom_range(9) == 0) ? 2 : 1,
				($urandom_range(19) == 0) ? 32'd0 : $urandom_range(48000, 1),
				bits, fsize, dsize, $urandom_range(dsize + 3),
				$urandom_range(1) ? -1 : $urandom_range(6));
			// broken files: one corrupted header byte or an early end
			if (r >= 70) begin
				if ($urandom_range(1)) begin
					file_q[$urandom_range(43)] = $urandom_range(255);
				end else begin
					truncate_to($urandom_range(file_q.size(), 1));
				end
			end
		end else begin
			file_q.delete();
			if ($urandom_range(1)) begin
				put_tag(TAG_RIFF);
			end
			repeat ($urandom_range(12, 1)) file_q.push_back($urandom_range(255));
		end
	endtask

	task automatic directed_cases();
		// 8-bit extremes; the last byte also uses up the data size
		make_wav(1, 1, 8000, 8, 16, 6, 0, -1);
		put_le(32'h7FFF_8000, 4);
		put_le(32'h8101, 2);
		send_file();
		// 16-bit extremes, extended fmt, empty skip chunk, ends on a lone low byte;
		// rate nonzero only in its top byte
		make_wav(1, 1, 32'h0100_0000, 16, 18, 16, 0, 0);
		put_le(32'h7FFF_8000, 4);
		put_le(32'hFFFF_0000, 4);
		put_le(32'hFF01_0100, 4);
		put_le(32'h55, 1);
		send_file();
		// short fmt size still takes 16 bytes; skipped chunk before it;
		// bytes past the data size are ignored
		make_wav(1, 1, 44100, 8, 2, 4, 6, 5);
		send_file();
		// bad RIFF tag, zero RIFF size, bad WAVE tag; the rest of the header is ignored
		make_wav(1, 1, 8000, 8, 16, 4, 4, -1);
		file_q[3] = 8'h58;
		truncate_to(8);
		send_file();
		make_wav(1, 1, 8000, 8, 16, 4, 4, -1);
		for (int i = 4; i < 8; i++) begin
			file_q[i] = 8'h00;
		end
		truncate_to(10);
		send_file();
		make_wav(1, 1, 8000, 8, 16, 4, 4, -1);
		file_q[11] = 8'h46;
		truncate_to(14);
		send_file();
		// early ends: in RIFF tag, size, WAVE tag, chunk id, fmt body, right after data size
		for (int k = 0; k < 6; k++) begin
			make_wav(1, 1, 8000, 8, 16, 4, 4, -1);
			case (k)
				0: truncate_to(1);
				1: truncate_to(6);
				2: truncate_to(10);
				3: truncate_to(15);
				4: truncate_to(30);
				default: truncate_to(44);
			endcase
			send_file();
		end
		// format rejects on the final byte: not PCM, stereo, 24 bits, zero rate, zero data size
		make_wav(3, 1, 8000, 8, 16, 4, 0, -1);
		send_file();
		make_wav(1, 2, 8000, 8, 16, 4, 0, -1);
		send_file();
		make_wav(1, 1, 8000, 24, 16, 6, 0, -1);
		send_file();
		make_wav(1, 1, 0, 8, 16, 4, 0, -1);
		send_file();
		make_wav(1, 1, 8000, 8, 16, 0, 0, -1);
		send_file();
		// data chunk with no fmt before it
		file_q.delete();
		put_tag(TAG_RIFF);
		put_le(12, 4);
		put_tag(TAG_WAVE);
		put_tag(TAG_DATA);
		put_le(4, 4);
		put_le(32'h1234_5678, 4);
		send_file();
		// data size below one 16-bit sample
		make_wav(1, 1, 8000, 16, 16, 1, 2, -1);
		send_file();
		// zero volume finishes at once; low volume gives a peak duty of one
		set_volume(7'd0);
		make_wav(1, 1, 8000, 8, 16, 4, 0, -1);
		send_file();
		set_volume(7'd10);
		make_wav(1, 1, 8000, 8, 16, 8, 0, -1);
		put_le(32'h01FF_8000, 4);
		put_le(32'h7F80_C040, 4);
		send_file();
	endtask

	initial begin
		int mid;
		byte_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		apb_access(1'b0, 32'd0);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 81; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 81; end
				default: begin send_idle = 30; recv_stall = 30; end
			endcase
			case (p)
				0: set_volume(7'd127);
				1: set_volume(7'd1);
				2: set_volume(7'd100);
				default: set_volume($urandom_range(127));
			endcase
			bytes_sent = 0;
			mid = 0;
			if (p == 0) begin
				// long receiver hold-off while a sample-heavy file keeps coming
				make_wav(1, 1, 8000, 8, 16, 12, 12, -1);
				hold_off = 400;
				send_file();
			end
			if (p == 3) begin
				// directed files under idling on both sides
				directed_cases();
			end else begin
				while (bytes_sent < 40) begin
					if (!mid && bytes_sent >= 20) begin
						set_volume($urandom_range(127));
						mid = 1;
					end
					random_file();
					if ($urandom_range(4) == 0) begin
						wait_drained();
					end
					send_file();
				end
			end
		end

		byte_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
